// ===== rtl/core/bbut_pkg.sv =====
// Shared types, codes and helpers for the bounding box union/transform block.
// No dependencies; used by every module under rtl/core.
package bbut_pkg;

   localparam int unsigned COORD_W = 32;
   localparam int unsigned AXES    = 3;
   localparam int unsigned CSR_W   = 64;
   localparam int unsigned NUM_CSR = 6;
   localparam int unsigned CSR_AW  = $clog2(NUM_CSR);
   localparam int unsigned FUNC_W  = 2;
   localparam int unsigned FRAC_W  = 16;
   localparam int unsigned PROD_W  = 2 * COORD_W;
   localparam int unsigned TERM_W  = PROD_W - FRAC_W;   // product after >>> 16
   localparam int unsigned SUM_W   = TERM_W + 2;        // translation + three terms
   localparam int unsigned BOX_W   = 2 * AXES * COORD_W;

   // operation codes
   localparam logic [FUNC_W-1:0] FUNC_MERGE     = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_TRANSFORM = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR     = 2'd2;

   // register indexes
   localparam logic [CSR_AW-1:0] CSR_XROW_A = 3'd0;
   localparam logic [CSR_AW-1:0] CSR_XROW_B = 3'd1;
   localparam logic [CSR_AW-1:0] CSR_YROW_A = 3'd2;
   localparam logic [CSR_AW-1:0] CSR_YROW_B = 3'd3;
   localparam logic [CSR_AW-1:0] CSR_ZROW_A = 3'd4;
   localparam logic [CSR_AW-1:0] CSR_ZROW_B = 3'd5;

   // identity matrix at reset
   localparam logic [CSR_W-1:0] XROW_A_RST = 64'h0000_0000_0001_0000;
   localparam logic [CSR_W-1:0] XROW_B_RST = 64'h0000_0000_0000_0000;
   localparam logic [CSR_W-1:0] YROW_A_RST = 64'h0001_0000_0000_0000;
   localparam logic [CSR_W-1:0] YROW_B_RST = 64'h0000_0000_0000_0000;
   localparam logic [CSR_W-1:0] ZROW_A_RST = 64'h0000_0000_0000_0000;
   localparam logic [CSR_W-1:0] ZROW_B_RST = 64'h0000_0000_0001_0000;

   localparam int unsigned COL_TR = 3;   // translation column of a row

   typedef logic signed [COORD_W-1:0] coord_type;

   // [0] coef x, [1] coef y, [2] coef z, [3] translation
   typedef coord_type [3:0] row_type;
   typedef row_type [AXES-1:0] mat_type;

   // lo in the low half, axis x lowest
   typedef struct packed {
      coord_type [AXES-1:0] hi;
      coord_type [AXES-1:0] lo;
   } box_type;

   function automatic coord_type sat32(input logic signed [SUM_W-1:0] v);
      coord_type r;
      if ((&v[SUM_W-1:COORD_W-1]) || !(|v[SUM_W-1:COORD_W-1])) begin
         r = v[COORD_W-1:0];
      end else if (v[SUM_W-1]) begin
         r = {1'b1, {(COORD_W-1){1'b0}}};
      end else begin
         r = {1'b0, {(COORD_W-1){1'b1}}};
      end
      return r;
   endfunction

endpackage

// ===== rtl/core/bbut_csr.sv =====
// Matrix register file: six 64-bit write-only registers, two Q16.16 terms each.
// Depends on bbut_pkg.
module bbut_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [bbut_pkg::CSR_AW-1:0]   csr_addr,
   input  logic [bbut_pkg::CSR_W-1:0]    csr_wdata,
   output bbut_pkg::mat_type             mat
);

   logic [bbut_pkg::CSR_W-1:0] xa_ff, xb_ff, ya_ff, yb_ff, za_ff, zb_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         xa_ff <= bbut_pkg::XROW_A_RST;
         xb_ff <= bbut_pkg::XROW_B_RST;
         ya_ff <= bbut_pkg::YROW_A_RST;
         yb_ff <= bbut_pkg::YROW_B_RST;
         za_ff <= bbut_pkg::ZROW_A_RST;
         zb_ff <= bbut_pkg::ZROW_B_RST;
      end else if (csr_we) begin
         unique case (csr_addr)
            bbut_pkg::CSR_XROW_A: xa_ff <= csr_wdata;
            bbut_pkg::CSR_XROW_B: xb_ff <= csr_wdata;
            bbut_pkg::CSR_YROW_A: ya_ff <= csr_wdata;
            bbut_pkg::CSR_YROW_B: yb_ff <= csr_wdata;
            bbut_pkg::CSR_ZROW_A: za_ff <= csr_wdata;
            bbut_pkg::CSR_ZROW_B: zb_ff <= csr_wdata;
            default: ;   // out-of-range index dropped
         endcase
      end
   end

   // {b, a} lines up as {translation, z, y, x}
   assign mat[0] = {xb_ff, xa_ff};
   assign mat[1] = {yb_ff, ya_ff};
   assign mat[2] = {zb_ff, za_ff};

endmodule

// ===== rtl/core/bbut_merge.sv =====
// Box union: takes over into an empty box, ignores an empty input, else grows per axis.
// Depends on bbut_pkg.
module bbut_merge (
   input  bbut_pkg::box_type cur,
   input  bbut_pkg::box_type inb,
   output bbut_pkg::box_type nxt,
   output logic              changed
);

   logic                      cur_empty, in_empty;
   logic [bbut_pkg::AXES-1:0] lo_mv, hi_mv;
   bbut_pkg::box_type         grown;

   assign cur_empty = (cur.lo == cur.hi);
   assign in_empty  = (inb.lo == inb.hi);

   always_comb begin
      for (int a = 0; a < bbut_pkg::AXES; a++) begin
         lo_mv[a] = $signed(inb.lo[a]) < $signed(cur.lo[a]);
         hi_mv[a] = $signed(inb.hi[a]) > $signed(cur.hi[a]);
         grown.lo[a] = lo_mv[a] ? inb.lo[a] : cur.lo[a];
         grown.hi[a] = hi_mv[a] ? inb.hi[a] : cur.hi[a];
      end
   end

   always_comb begin
      if (cur_empty) begin
         nxt     = inb;
         changed = 1'b1;
      end else if (in_empty) begin
         nxt     = cur;
         changed = 1'b0;
      end else begin
         nxt     = grown;
         changed = (|lo_mv) | (|hi_mv);
      end
   end

endmodule

// ===== rtl/core/bbut_xform.sv =====
// Affine box transform, per-axis min/max of corner products plus translation.
// Depends on bbut_pkg. One 32x32 multiply per product, then add and saturate.
module bbut_xform (
   input  bbut_pkg::box_type cur,
   input  bbut_pkg::mat_type mat,
   output bbut_pkg::box_type nxt
);

   for (genvar r = 0; r < bbut_pkg::AXES; r++) begin : g_row
      logic signed [bbut_pkg::TERM_W-1:0] tmin [bbut_pkg::AXES];
      logic signed [bbut_pkg::TERM_W-1:0] tmax [bbut_pkg::AXES];
      logic signed [bbut_pkg::SUM_W-1:0]  smin, smax;

      for (genvar c = 0; c < bbut_pkg::AXES; c++) begin : g_col
         logic signed [bbut_pkg::PROD_W-1:0] plo, phi;
         logic signed [bbut_pkg::TERM_W-1:0] p, q;
         assign plo = $signed(cur.lo[c]) * $signed(mat[r][c]);
         assign phi = $signed(cur.hi[c]) * $signed(mat[r][c]);
         // dropping the fraction bits floors, as an arithmetic shift does
         assign p = plo[bbut_pkg::PROD_W-1:bbut_pkg::FRAC_W];
         assign q = phi[bbut_pkg::PROD_W-1:bbut_pkg::FRAC_W];
         assign tmin[c] = (p < q) ? p : q;
         assign tmax[c] = (p > q) ? p : q;
      end

      assign smin = bbut_pkg::SUM_W'($signed(mat[r][bbut_pkg::COL_TR]))
                  + bbut_pkg::SUM_W'(tmin[0]) + bbut_pkg::SUM_W'(tmin[1])
                  + bbut_pkg::SUM_W'(tmin[2]);
      assign smax = bbut_pkg::SUM_W'($signed(mat[r][bbut_pkg::COL_TR]))
                  + bbut_pkg::SUM_W'(tmax[0]) + bbut_pkg::SUM_W'(tmax[1])
                  + bbut_pkg::SUM_W'(tmax[2]);

      assign nxt.lo[r] = bbut_pkg::sat32(smin);
      assign nxt.hi[r] = bbut_pkg::sat32(smax);
   end

endmodule

// ===== rtl/core/bounding_box_union_and_transform.sv =====
// Top level of the bounding box union/transform block.
// Depends on bbut_pkg, bbut_csr, bbut_merge, bbut_xform.
//
//  channel | dir | ports            | word
//  --------+-----+------------------+-------------------------------------------
//  req     | in  | tvalid/tready    | tdata: in box (192b), tuser: func (2b)
//  rsp     | out | tvalid/tready    | tdata: updated box (192b), tuser: changed
//  csr     | in  | we/addr/wdata    | 64-bit matrix row halves, index 0..5
//
// One word per cycle sustained while rsp_tready stays high. The request word is
// registered, then merge / transform / clear runs in one combinational pass
// from that register and the box state into the box and response registers.
// The transform pass is one 32x32 multiply, a four-input add and a saturate.
// Synchronous active-high reset clears the box to zero and loads the
// identity matrix. A stalled response holds; a new request is still taken
// while the input register is free, so the two sides are decoupled.
module bounding_box_union_and_transform (
   input  logic                                clock,
   input  logic                                reset,
   // request
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // in_min_x, in_min_y, in_min_z, in_max_x, in_max_y, in_max_z (lowest first)
   input  logic [bbut_pkg::BOX_W-1:0]          req_tdata,
   // func
   input  logic [bbut_pkg::FUNC_W-1:0]         req_tuser,
   // response
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // res_min_x, res_min_y, res_min_z, res_max_x, res_max_y, res_max_z
   output logic [bbut_pkg::BOX_W-1:0]          rsp_tdata,
   // changed
   output logic                                rsp_tuser,
   // configuration
   input  logic                                csr_we,
   input  logic [bbut_pkg::CSR_AW-1:0]         csr_addr,
   input  logic [bbut_pkg::CSR_W-1:0]          csr_wdata
);

   bbut_pkg::mat_type             mat;
   bbut_pkg::box_type             box_ff, box_in;
   bbut_pkg::box_type             inb_ff;
   logic [bbut_pkg::FUNC_W-1:0]   func_ff;
   logic                          in_vld_ff, in_vld_in;
   logic                          rsp_vld_ff, rsp_vld_in;
   logic [bbut_pkg::BOX_W-1:0]    rsp_data_ff;
   logic                          rsp_chg_ff, chg_in;
   bbut_pkg::box_type             merge_box, xform_box;
   logic                          merge_chg;
   logic                          req_acc, advance;

   bbut_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .mat       (mat)
   );

   bbut_merge u_merge (
      .cur     (box_ff),
      .inb     (inb_ff),
      .nxt     (merge_box),
      .changed (merge_chg)
   );

   bbut_xform u_xform (
      .cur (box_ff),
      .mat (mat),
      .nxt (xform_box)
   );

   // stage 1 moves on when the response register is free or being drained
   assign advance    = in_vld_ff && (!rsp_vld_ff || rsp_tready);
   assign req_tready = !in_vld_ff || advance;
   assign req_acc    = req_tvalid && req_tready;

   assign in_vld_in  = req_acc ? 1'b1 : (advance ? 1'b0 : in_vld_ff);
   assign rsp_vld_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : rsp_vld_ff);

   // operation decode
   always_comb begin
      unique case (func_ff)
         bbut_pkg::FUNC_MERGE: begin
            box_in = merge_box;
            chg_in = merge_chg;
         end
         bbut_pkg::FUNC_TRANSFORM: begin
            box_in = xform_box;
            chg_in = 1'b0;
         end
         bbut_pkg::FUNC_CLEAR: begin
            box_in = '0;
            chg_in = 1'b0;
         end
         default: begin   // unused code: box returned as is
            box_in = box_ff;
            chg_in = 1'b0;
         end
      endcase
   end

   // control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
         box_ff     <= '0;
      end else begin
         in_vld_ff  <= in_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         if (advance) begin
            box_ff <= box_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_acc) begin
         inb_ff  <= req_tdata;
         func_ff <= req_tuser;
      end
      if (advance) begin
         rsp_data_ff <= box_in;
         rsp_chg_ff  <= chg_in;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_chg_ff;

endmodule

// ===== test/tb_top.sv =====
// Self-checking bench for bounding_box_union_and_transform: a directed run and then random
// words, checked against an in-bench predictor of the box and matrix state.
// Depends on bbut_pkg and the block's RTL only.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   // func value with no operation behind it: box held, changed low
   localparam logic [bbut_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;

   localparam bbut_pkg::coord_type C_MIN = 32'sh8000_0000;
   localparam bbut_pkg::coord_type C_MAX = 32'sh7FFF_FFFF;
   localparam bbut_pkg::coord_type ONE   = 32'sh0001_0000;   // 1.0 in Q16.16

   localparam int PHASE_WORDS = 150;   // random words per matrix setting
   localparam int DRAIN_GAP   = 4;     // settling margin after the last response
   localparam int STALL_LIMIT = 2000;  // cycles with no handshake or register write

   typedef enum {MX_SMALL, MX_FULL, MX_MIXED} mat_mode_type;

   // one request word: func in tuser, box in tdata
   typedef struct packed {
      logic [bbut_pkg::FUNC_W-1:0] op;
      bbut_pkg::box_type           box;
   } req_word_type;

   // one response word: box in tdata, changed in tuser
   typedef struct packed {
      bbut_pkg::box_type box;
      logic              chg;
   } rsp_word_type;

   logic                          clock;
   logic                          reset      = 1'b1;
   logic                          req_tvalid = 1'b0;
   logic                          req_tready;
   // in_min_x/y/z, in_max_x/y/z, lowest first
   logic [bbut_pkg::BOX_W-1:0]    req_tdata  = '0;
   logic [bbut_pkg::FUNC_W-1:0]   req_tuser  = '0;   // func
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   logic [bbut_pkg::BOX_W-1:0]    rsp_tdata;   // res_min_x/y/z, res_max_x/y/z, lowest first
   logic                          rsp_tuser;   // changed
   logic                          csr_we     = 1'b0;
   logic [bbut_pkg::CSR_AW-1:0]   csr_addr   = '0;
   logic [bbut_pkg::CSR_W-1:0]    csr_wdata  = '0;

   req_word_type      word_queue[$];     // words waiting for the driver
   rsp_word_type      box_expected[$];   // predicted responses, oldest first
   req_word_type      driven;            // word currently presented on req
   bbut_pkg::box_type box_now = '0;      // predicted box state
   logic [bbut_pkg::CSR_W-1:0] shadow [bbut_pkg::NUM_CSR] =
      '{bbut_pkg::XROW_A_RST, bbut_pkg::XROW_B_RST, bbut_pkg::YROW_A_RST,
        bbut_pkg::YROW_B_RST, bbut_pkg::ZROW_A_RST, bbut_pkg::ZROW_B_RST};
   int snd_idle = 0;             // percent of free cycles the sender sits out
   int rcv_idle = 0;             // percent of cycles rsp_tready is low
   int failures = 0;
   int stall_cycles = 0;
   string axis_tag = "xyz";

   bounding_box_union_and_transform dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------------

   function automatic longint sx(input logic [bbut_pkg::COORD_W-1:0] v);
      return longint'($signed(v));
   endfunction

   // row 0..2; col 0..2 coefficient of x/y/z, COL_TR the translation.
   // Each row is two registers: a holds x,y coefficients, b holds z and translation.
   function automatic longint mat_term(input int row, input int col);
      logic [bbut_pkg::CSR_W-1:0] r;
      r = shadow[2 * row + col / 2];
      return (col % 2) ? sx(r[63:32]) : sx(r[31:0]);
   endfunction

   function automatic bbut_pkg::coord_type clamp32(input longint v);
      if (v > longint'(C_MAX)) return C_MAX;
      if (v < longint'(C_MIN)) return C_MIN;
      return bbut_pkg::coord_type'(v);
   endfunction

   // Applies one word to the predicted box and returns the response it yields.
   function automatic rsp_word_type apply_word(input req_word_type w);
      rsp_word_type      r;
      bbut_pkg::box_type nb;
      longint            lo_sum, hi_sum, k, p, q;
      r.chg = 1'b0;
      case (w.op)
         bbut_pkg::FUNC_MERGE: begin
            if (box_now.lo == box_now.hi) begin
               // empty stored box: taken over wholesale, even by an identical box
               box_now = w.box;
               r.chg   = 1'b1;
            end else if (w.box.lo != w.box.hi) begin
               // empty input is ignored; otherwise grow per axis, no order check
               for (int a = 0; a < bbut_pkg::AXES; a++) begin
                  if (sx(w.box.lo[a]) < sx(box_now.lo[a])) begin
                     box_now.lo[a] = w.box.lo[a];
                     r.chg = 1'b1;
                  end
                  if (sx(w.box.hi[a]) > sx(box_now.hi[a])) begin
                     box_now.hi[a] = w.box.hi[a];
                     r.chg = 1'b1;
                  end
               end
            end
         end
         bbut_pkg::FUNC_TRANSFORM: begin
            // Arvo: per output axis pick the smaller/larger corner product per column
            for (int row = 0; row < bbut_pkg::AXES; row++) begin
               lo_sum = mat_term(row, bbut_pkg::COL_TR);
               hi_sum = lo_sum;
               for (int c = 0; c < bbut_pkg::AXES; c++) begin
                  k = mat_term(row, c);
                  p = (sx(box_now.lo[c]) * k) >>> bbut_pkg::FRAC_W;   // floor
                  q = (sx(box_now.hi[c]) * k) >>> bbut_pkg::FRAC_W;
                  lo_sum += (p < q) ? p : q;
                  hi_sum += (p > q) ? p : q;
               end
               nb.lo[row] = clamp32(lo_sum);
               nb.hi[row] = clamp32(hi_sum);
            end
            box_now = nb;
         end
         bbut_pkg::FUNC_CLEAR: box_now = '0;
         default: ;
      endcase
      r.box = box_now;
      return r;
   endfunction

   // ---------------------------------------------------------------------------
   // Driver: presents queued words, with random gaps between them
   // ---------------------------------------------------------------------------

   always @(posedge clock) begin : feed
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            box_expected.push_back(apply_word(driven));
         end
         if (!req_tvalid || req_tready) begin
            if (word_queue.size() != 0 && $urandom_range(99) >= snd_idle) begin
               driven = word_queue.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= driven.box;
               req_tuser  <= driven.op;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Monitor: random back-pressure, field-by-field check of every response word
   // ---------------------------------------------------------------------------

   always @(posedge clock) begin : sink
      rsp_word_type      want;
      bbut_pkg::box_type got;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (box_expected.size() == 0) begin
               failures++;
               $display("%0t: response word with nothing expected: expected none, got %h/%b",
                        $time, rsp_tdata, rsp_tuser);
            end else begin
               want = box_expected.pop_front();
               for (int a = 0; a < bbut_pkg::AXES; a++) begin
                  if (got.lo[a] !== want.box.lo[a]) begin
                     failures++;
                     $display("%0t: res_min_%c expected %0d got %0d", $time,
                              axis_tag[a], $signed(want.box.lo[a]), $signed(got.lo[a]));
                  end
                  if (got.hi[a] !== want.box.hi[a]) begin
                     failures++;
                     $display("%0t: res_max_%c expected %0d got %0d", $time,
                              axis_tag[a], $signed(want.box.hi[a]), $signed(got.hi[a]));
                  end
               end
               if (rsp_tuser !== want.chg) begin
                  failures++;
                  $display("%0t: changed expected %b got %b", $time, want.chg, rsp_tuser);
               end
            end
         end
         rsp_tready <= ($urandom_range(99) >= rcv_idle);
      end
   end

   // Ends a hung run: counts cycles in which no handshake or register write happens.
   always @(posedge clock) begin : watchdog
      if (reset || csr_we || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles == STALL_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------

   task automatic post(input logic [bbut_pkg::FUNC_W-1:0] op,
                       input bbut_pkg::coord_type nx, ny, nz,
                       input bbut_pkg::coord_type xx, xy, xz);
      req_word_type w;
      w.op = op;
      w.box.lo[0] = nx;  w.box.lo[1] = ny;  w.box.lo[2] = nz;
      w.box.hi[0] = xx;  w.box.hi[1] = xy;  w.box.hi[2] = xz;
      word_queue.push_back(w);
   endtask

   // Waits until every queued word has gone and been answered,
   // then lets the pipeline settle so a register write finds the block idle.
   // Checked at the falling edge, once the driver and monitor have both moved.
   task automatic drain();
      @(negedge clock);
      while (word_queue.size() != 0 || req_tvalid || box_expected.size() != 0)
         @(negedge clock);
      repeat (DRAIN_GAP) @(posedge clock);
   endtask

   task automatic write_reg(input logic [bbut_pkg::CSR_AW-1:0] idx,
                            input logic [bbut_pkg::CSR_W-1:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      shadow[idx] = val;
   endtask

   // back-to-back writes of all six registers; we dropped only after the last
   task automatic load_matrix(input logic [bbut_pkg::CSR_W-1:0] xa, xb, ya, yb, za, zb);
      write_reg(bbut_pkg::CSR_XROW_A, xa);
      write_reg(bbut_pkg::CSR_XROW_B, xb);
      write_reg(bbut_pkg::CSR_YROW_A, ya);
      write_reg(bbut_pkg::CSR_YROW_B, yb);
      write_reg(bbut_pkg::CSR_ZROW_A, za);
      write_reg(bbut_pkg::CSR_ZROW_B, zb);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic bbut_pkg::coord_type rand_term(input mat_mode_type m);
      bbut_pkg::coord_type small_k;
      // +/-4.0
      small_k = bbut_pkg::coord_type'(int'($urandom_range(0, 1 << 19)) - (1 << 18));
      case (m)
         MX_SMALL: return small_k;
         MX_FULL:  return bbut_pkg::coord_type'($urandom);
         default: begin
            case ($urandom_range(3))
               0:       return C_MIN;
               1:       return C_MAX;
               default: return small_k;
            endcase
         end
      endcase
   endfunction

   function automatic logic [bbut_pkg::CSR_W-1:0] rand_reg(input mat_mode_type m);
      return {rand_term(m), rand_term(m)};
   endfunction

   function automatic bbut_pkg::coord_type rand_coord();
      case ($urandom_range(9))
         0:       return C_MIN;
         1:       return C_MAX;
         2, 3:    return bbut_pkg::coord_type'($urandom);
         default: return bbut_pkg::coord_type'(int'($urandom_range(0, 1 << 22)) - (1 << 21));
      endcase
   endfunction

   // Mostly merges of well-formed boxes near the origin so growth and no-growth
   // both happen; the rest are empty, inverted or raw boxes and the other funcs.
   function automatic req_word_type make_word();
      req_word_type w;
      int           roll;
      int unsigned  d;
      roll = $urandom_range(99);
      if (roll < 58)      w.op = bbut_pkg::FUNC_MERGE;
      else if (roll < 80) w.op = bbut_pkg::FUNC_TRANSFORM;
      else if (roll < 92) w.op = bbut_pkg::FUNC_CLEAR;
      else                w.op = FUNC_UNUSED;
      for (int a = 0; a < bbut_pkg::AXES; a++) begin
         w.box.lo[a] = rand_coord();
         w.box.hi[a] = bbut_pkg::coord_type'($urandom);
      end
      if (w.op == bbut_pkg::FUNC_MERGE) begin
         roll = $urandom_range(99);
         for (int a = 0; a < bbut_pkg::AXES; a++) begin
            d = $urandom_range(1, 1 << 20);
            if (roll < 70)      w.box.hi[a] = bbut_pkg::coord_type'(w.box.lo[a] + d);
            else if (roll < 80) w.box.hi[a] = w.box.lo[a];
            else if (roll < 90) w.box.hi[a] = bbut_pkg::coord_type'(w.box.lo[a] - d);
         end
      end
      return w;
   endfunction

   // ---------------------------------------------------------------------------
   // Sequence: reset, directed words under three matrices, six random phases
   // ---------------------------------------------------------------------------

   initial begin : main
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // first idling pattern: sender 33 %, receiver 54 %
      snd_idle = 33;
      rcv_idle = 54;

      // identity matrix from reset
      post(bbut_pkg::FUNC_MERGE, 0, 0, 0, 0, 0, 0);                  // empty into empty
      post(bbut_pkg::FUNC_MERGE, -ONE, -2 * ONE, -3 * ONE,
           ONE, 2 * ONE, 3 * ONE);                                    // take over
      post(bbut_pkg::FUNC_MERGE, 5 * ONE, 5 * ONE, 5 * ONE,
           5 * ONE, 5 * ONE, 5 * ONE);                                // empty in
      post(bbut_pkg::FUNC_MERGE, 0, 0, 0, ONE / 2, ONE / 2, ONE / 2); // contained
      post(bbut_pkg::FUNC_MERGE, C_MIN, 0, 0, 0, 0, 0);              // grows min x only
      post(bbut_pkg::FUNC_MERGE, 0, 0, 0, C_MAX, C_MAX, C_MAX);      // grows every max
      post(bbut_pkg::FUNC_MERGE, C_MAX, C_MAX, C_MAX,
           C_MIN, C_MIN, C_MIN);                                      // inverted input
      post(bbut_pkg::FUNC_TRANSFORM, C_MAX, C_MIN, 1, -1, 0, ONE);   // box fields ignored
      post(FUNC_UNUSED, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX);
      post(bbut_pkg::FUNC_CLEAR, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN);
      post(bbut_pkg::FUNC_MERGE, 3 * ONE, 3 * ONE, 3 * ONE,
           -ONE, -ONE, -ONE);                                         // inverted taken over
      post(bbut_pkg::FUNC_TRANSFORM, 0, 0, 0, 0, 0, 0);
      post(bbut_pkg::FUNC_MERGE, C_MIN, C_MIN, C_MIN,
           C_MAX, C_MAX, C_MAX);                                      // full range
      drain();

      // extreme terms: x row saturates high, y row all most-negative,
      // z row mixed with a one-LSB z coefficient to show floor rounding
      load_matrix({C_MAX, C_MAX}, {C_MAX, C_MAX}, {C_MIN, C_MIN}, {C_MIN, C_MIN},
                  {C_MAX, C_MIN}, {C_MIN, 32'sd1});
      post(bbut_pkg::FUNC_TRANSFORM, 0, 0, 0, 0, 0, 0);
      post(bbut_pkg::FUNC_TRANSFORM, 0, 0, 0, 0, 0, 0);
      post(bbut_pkg::FUNC_CLEAR, 0, 0, 0, 0, 0, 0);
      post(bbut_pkg::FUNC_MERGE, -1, -1, -1, 1, 1, 1);
      post(bbut_pkg::FUNC_MERGE, -ONE, -ONE, -ONE, ONE, ONE, ONE);
      post(bbut_pkg::FUNC_TRANSFORM, 0, 0, 0, 0, 0, 0);
      drain();

      // all-zero matrix collapses the box to the origin, which then counts as empty
      load_matrix('0, '0, '0, '0, '0, '0);
      post(bbut_pkg::FUNC_TRANSFORM, 0, 0, 0, 0, 0, 0);
      post(bbut_pkg::FUNC_MERGE, -7 * ONE, 2 * ONE, C_MIN, 9 * ONE, 4 * ONE, C_MAX);
      post(bbut_pkg::FUNC_TRANSFORM, 0, 0, 0, 0, 0, 0);
      drain();

      // random phases, each with a fresh matrix; idling pattern moves on every two
      for (int ph = 0; ph < 6; ph++) begin
         if (ph == 2) begin
            snd_idle = 54;
            rcv_idle = 33;
         end else if (ph == 4) begin
            snd_idle = 0;
            rcv_idle = 0;
         end
         case (ph)
            1:  load_matrix(rand_reg(MX_FULL), rand_reg(MX_FULL), rand_reg(MX_FULL),
                            rand_reg(MX_FULL), rand_reg(MX_FULL), rand_reg(MX_FULL));
            3:  load_matrix(rand_reg(MX_MIXED), rand_reg(MX_MIXED), rand_reg(MX_MIXED),
                            rand_reg(MX_MIXED), rand_reg(MX_MIXED), rand_reg(MX_MIXED));
            5:  load_matrix(bbut_pkg::XROW_A_RST, bbut_pkg::XROW_B_RST,
                            bbut_pkg::YROW_A_RST, bbut_pkg::YROW_B_RST,
                            bbut_pkg::ZROW_A_RST, bbut_pkg::ZROW_B_RST);
            default:
                load_matrix(rand_reg(MX_SMALL), rand_reg(MX_SMALL), rand_reg(MX_SMALL),
                            rand_reg(MX_SMALL), rand_reg(MX_SMALL), rand_reg(MX_SMALL));
         endcase
         for (int n = 0; n < PHASE_WORDS; n++)
            word_queue.push_back(make_word());
         drain();
      end

      if (box_expected.size() != 0)
         failures++;
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
